// ===== rtl/yse_pkg.sv =====
// Package: shared types, constants and byte codes for the YAML string escape encoder.
`timescale 1ns / 1ps
`default_nettype none
package yse_pkg;

  localparam logic [7:0] PrintLow    = 8'h20;
  localparam logic [7:0] PrintHigh   = 8'h7e;
  localparam logic [7:0] EscChar     = 8'h1b;
  localparam logic [3:0] NibbleMask  = 4'hf;
  localparam logic [7:0] Backslash   = 8'h5c;
  localparam logic [7:0] Quote       = 8'h22;
  localparam logic [7:0] Slash       = 8'h2f;
  localparam logic [7:0] LetterX     = 8'h78;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    KindPlain,
    KindShort,
    KindHex
  } kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_t;

  // Classified item: plain byte, short-escape letter, or raw byte for hex.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       eos;
  } desc_t;

endpackage
`default_nettype wire

// ===== rtl/yaml_string_escape_encoder.sv =====
// Top level: YAML double-quoted string escape encoder.
// Usage:
//   Input queue side: drive in_data_i and raise push; a byte is transferred
//   at a clock edge with push high and full low.
//   Output queue side: while empty is low the oldest escaped byte sits on
//   out_data_o; it is transferred at an edge with pop high.
//   Each input byte yields 1, 2 or 4 output bytes; run_last marks the final
//   one and string_end copies end_of_string onto it.
// Path: an item transferred in is written to the queue; its first output byte
//   is then loaded into the output register once the output side is free.
// Throughput: one output byte per cycle while pop stays high and the queue
//   holds an item; the output sequencer is the limit.
// A two-entry queue separates classification from sequencing, so input keeps
//   flowing while a result waits to be popped.
// Reset: the queue and output register are emptied; empty goes high.
// Stall: with pop low the output byte holds; the queue fills, then full rises.
`timescale 1ns / 1ps
`default_nettype none
module yaml_string_escape_encoder (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire yse_pkg::in_t  in_data_i,
  output logic               empty,
  input  wire logic          pop,
  output yse_pkg::out_t      out_data_o
);
  import yse_pkg::*;

  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  desc_t desc;
  desc_t head;

  assign full = q_full;

  yse_front u_front (
    .push_i    (push),
    .in_data_i (in_data_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .desc_o    (desc)
  );

  yse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .desc_i  (desc),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  yse_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_data_o (out_data_o)
  );

`ifndef SYNTH
  a_q_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_full && q_empty))
    else $error("queue full and empty together");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> !q_empty)
    else $error("transferred item missing from queue");

  a_run_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_data_o.run_last) |-> !q_empty)
    else $error("item left queue before its run ended");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.string_end) |-> out_data_o.run_last)
    else $error("string end not on last byte of run");
`endif

endmodule
`default_nettype wire

// ===== rtl/yse_front.sv =====
// Front end: classifies each accepted byte into plain, short escape or hex escape.
`timescale 1ns / 1ps
`default_nettype none
module yse_front (
  input  wire logic          push_i,
  input  wire yse_pkg::in_t  in_data_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output yse_pkg::desc_t     desc_o
);
  import yse_pkg::*;

  logic [7:0] letter;
  logic       has_short;

  always_comb begin
    has_short = 1'b1;
    case (in_data_i.in_byte)
      8'h00:     letter = 8'h30;
      8'h07:     letter = 8'h61;
      8'h08:     letter = 8'h62;
      8'h09:     letter = 8'h74;
      8'h0a:     letter = 8'h6e;
      8'h0b:     letter = 8'h76;
      8'h0c:     letter = 8'h66;
      8'h0d:     letter = 8'h72;
      EscChar:   letter = 8'h65;
      Quote:     letter = Quote;
      Slash:     letter = Slash;
      Backslash: letter = Backslash;
      default: begin
        letter    = 8'h00;
        has_short = 1'b0;
      end
    endcase
  end

  always_comb begin
    desc_o.eos = in_data_i.end_of_string;
    if (has_short) begin
      desc_o.kind = KindShort;
      desc_o.data = letter;
    end else if (in_data_i.in_byte inside {[PrintLow:PrintHigh]}) begin
      desc_o.kind = KindPlain;
      desc_o.data = in_data_i.in_byte;
    end else begin
      desc_o.kind = KindHex;
      desc_o.data = in_data_i.in_byte;
    end
  end

  assign q_push_o = push_i && !q_full_i;

endmodule
`default_nettype wire

// ===== rtl/yse_queue.sv =====
// Short queue of classified items between front end and output sequencer.
`timescale 1ns / 1ps
`default_nettype none
module yse_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire yse_pkg::desc_t  desc_i,
  input  wire logic            pop_i,
  output logic                 full_o,
  output logic                 empty_o,
  output yse_pkg::desc_t       head_o
);
  import yse_pkg::*;

  desc_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wptr_q, wptr_d;
  logic [QPtrW-1:0]  rptr_q, rptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wptr_d = push_i ? ptr_inc(wptr_q) : wptr_q;
    rptr_d = do_pop ? ptr_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q + QCntW'(push_i) - QCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= desc_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/yse_back.sv =====
// Back end: walks the escape sequence of the queue head into the output register.
`timescale 1ns / 1ps
`default_nettype none
module yse_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire yse_pkg::desc_t  head_i,
  input  wire logic            q_empty_i,
  output logic                 q_pop_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output yse_pkg::out_t        out_data_o
);
  import yse_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  out_t       out_q, out_d;
  logic       advance;
  logic       last;
  logic [7:0] cur_byte;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [3:0] n;
    n = v & NibbleMask;
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h41 + {4'h0, n} - 8'd10);
  endfunction

  assign advance = !q_empty_i && (!vld_q || pop_i);

  always_comb begin
    case (idx_q)
      2'd0:    cur_byte = (head_i.kind == KindPlain) ? head_i.data : Backslash;
      2'd1:    cur_byte = (head_i.kind == KindShort) ? head_i.data : LetterX;
      2'd2:    cur_byte = hex_digit(head_i.data[7:4]);
      default: cur_byte = hex_digit(head_i.data[3:0]);
    endcase
    case (head_i.kind)
      KindPlain: last = 1'b1;
      KindShort: last = (idx_q == 2'd1);
      default:   last = (idx_q == 2'd3);
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    vld_d = vld_q;
    out_d = out_q;
    if (advance) begin
      vld_d            = 1'b1;
      out_d.out_byte   = cur_byte;
      out_d.run_last   = last;
      out_d.string_end = last && head_i.eos;
      idx_d            = last ? 2'd0 : idx_q + 2'd1;
    end else if (pop_i) begin
      vld_d = 1'b0;
    end
  end

  assign q_pop_o    = advance && last;
  assign empty_o    = !vld_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule
`default_nettype wire
